// File: design/ultimate_oscillator_unit_assert.svh
// Assertion macros shared by the ultimate oscillator unit.
`ifndef ULTIMATE_OSCILLATOR_UNIT_ASSERT_SVH
`define ULTIMATE_OSCILLATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UOU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UOU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/uo_pkg.sv
// Shared types, codes and constants of the ultimate oscillator unit.
`timescale 1ns / 1ps
`default_nettype none

package uo_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned MAX_PERIOD_DEF    = 64;
  localparam int unsigned PRICE_BITS_DEF    = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Configuration registers
  localparam int unsigned REG_W      = 7;
  localparam int unsigned REG_COUNT  = 3;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_SHORT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MID   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LONG  = 2'd2;

  localparam logic [REG_W-1:0] SHORT_RESET = 7'd7;
  localparam logic [REG_W-1:0] MID_RESET   = 7'd14;
  localparam logic [REG_W-1:0] LONG_RESET  = 7'd28;

  // Window selectors used while sweeping the three sums
  localparam logic [1:0] WIN_SHORT = 2'd0;
  localparam logic [1:0] WIN_MID   = 2'd1;
  localparam logic [1:0] WIN_LONG  = 2'd2;

  // Output scaling: floor(100*acc/7) = 14*acc + floor(2*acc/7)
  localparam int unsigned OSC_SCALE = 100;
  localparam int unsigned DIVISOR   = 7;
  localparam int unsigned MUL_INT   = OSC_SCALE / DIVISOR;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    STATUS_WARMUP = 2'd0,
    STATUS_VALID  = 2'd1,
    STATUS_BAD    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_ACC,
    BK_WRITE,
    BK_EVAL,
    BK_DIV_START,
    BK_DIV_WAIT,
    BK_SCALE,
    BK_FINISH
  } back_state_e;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [REG_W-1:0] short_p;
    logic [REG_W-1:0] mid_p;
    logic [REG_W-1:0] long_p;
    logic             bad;
    logic             clear;
  } cfg_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// File: design/uo_front.sv
// Front end: accepts price bars and forms buying pressure and true range.
`timescale 1ns / 1ps
`default_nettype none

module uo_front import uo_pkg::*; #(
  parameter int unsigned PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         clear_i,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [PRICE_BITS-1:0]       high_i,
  input  wire  [PRICE_BITS-1:0]       low_i,
  input  wire  [PRICE_BITS-1:0]       close_i,
  output logic                        push_valid_o,
  input  wire                         push_ready_i,
  output logic                        push_first_o,
  output logic signed [PRICE_BITS:0]  push_bp_o,
  output logic [PRICE_BITS-1:0]       push_tr_o
);

  logic [PRICE_BITS-1:0] last_close_q, last_close_d;
  logic                  have_close_q, have_close_d;
  logic [PRICE_BITS-1:0] lo_floor, hi_ceil;
  logic                  accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  // True low/high against the previous close
  always_comb begin
    lo_floor = (low_i < last_close_q) ? low_i : last_close_q;
    hi_ceil  = (high_i > last_close_q) ? high_i : last_close_q;
    push_first_o = !have_close_q;
    if (have_close_q) begin
      push_bp_o = signed'({1'b0, close_i} - {1'b0, lo_floor});
      push_tr_o = hi_ceil - lo_floor;
    end else begin
      push_bp_o = '0;
      push_tr_o = '0;
    end
  end

  // Previous close tracking
  always_comb begin
    last_close_d = last_close_q;
    have_close_d = have_close_q;
    if (clear_i) begin
      last_close_d = '0;
      have_close_d = 1'b0;
    end else if (accept) begin
      last_close_d = close_i;
      have_close_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_close_q <= '0;
      have_close_q <= 1'b0;
    end else begin
      last_close_q <= last_close_d;
      have_close_q <= have_close_d;
    end
  end

endmodule

`default_nettype wire

// File: design/uo_fifo.sv
// Small queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module uo_fifo import uo_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_valid_i,
  output logic             push_ready_o,
  input  wire  [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  wire              pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = data_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/uo_div.sv
// Restoring divider: window ratio num/den in [0,1], one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module uo_div import uo_pkg::*; #(
  parameter int unsigned DEN_W     = 38,
  parameter int unsigned NUM_W     = 39,
  parameter int unsigned FRAC_BITS = FRACTION_BITS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire  signed [NUM_W-1:0]  num_i,
  input  wire  [DEN_W-1:0]         den_i,
  output logic [FRAC_BITS:0]       quot_o,
  output div_sts_t                 sts_o
);

  localparam int unsigned CW = $clog2(FRAC_BITS + 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [DEN_W-1:0]  rem_q, den_q, rem_next;
  logic [FRAC_BITS:0] quot_q;
  logic [DEN_W:0]    rem_sh;
  logic              ge, num_pos, num_ge;

  assign quot_o = quot_q;
  assign sts_o  = '{busy: busy_q, done: done_q};

  // One restoring step and the early-out checks
  always_comb begin
    rem_sh   = {rem_q, 1'b0};
    ge       = (rem_sh >= {1'b0, den_q});
    rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
    num_pos  = !num_i[NUM_W-1] && (num_i != '0);
    num_ge   = (unsigned'(num_i) >= {{(NUM_W-DEN_W){1'b0}}, den_i});
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
      if ((den_i == '0) || !num_pos || num_ge) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(FRAC_BITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[DEN_W-1:0];
      den_q <= den_i;
      if ((den_i == '0) || !num_pos) begin
        quot_q <= '0;
      end else if (num_ge) begin
        quot_q <= (FRAC_BITS + 1)'(1) << FRAC_BITS;
      end else begin
        quot_q <= '0;
      end
    end else if (busy_q) begin
      rem_q  <= rem_next;
      quot_q <= {quot_q[FRAC_BITS-1:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: design/uo_back.sv
// Back end: ring, window sums, ratios and output scaling of one bar.
`timescale 1ns / 1ps
`default_nettype none

module uo_back import uo_pkg::*; #(
  parameter int unsigned MAX_PERIOD    = MAX_PERIOD_DEF,
  parameter int unsigned PRICE_BITS    = PRICE_BITS_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cfg_t                         cfg_i,
  input  wire                          pop_valid_i,
  output logic                         pop_ready_o,
  input  wire                          pop_first_i,
  input  wire  signed [PRICE_BITS:0]   pop_bp_i,
  input  wire  [PRICE_BITS-1:0]        pop_tr_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [FRACTION_BITS+6:0]     out_osc_o,
  output logic [1:0]                   out_status_o,
  output logic signed [PRICE_BITS:0]   out_bp_o,
  output logic [PRICE_BITS-1:0]        out_tr_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_PERIOD + 1);
  localparam int unsigned PTR_W  = $clog2(MAX_PERIOD);
  localparam int unsigned IW     = CNT_W + 1;
  localparam int unsigned BP_W   = PRICE_BITS + 1;
  localparam int unsigned PS_W   = BP_W + PTR_W;
  localparam int unsigned RS_W   = PRICE_BITS + PTR_W;
  localparam int unsigned MEM_W  = BP_W + PRICE_BITS;
  localparam int unsigned RAT_W  = FRACTION_BITS + 1;
  localparam int unsigned ACC_W  = FRACTION_BITS + 3;
  localparam int unsigned OSC_W  = FRACTION_BITS + 7;
  localparam int unsigned DVD_W  = ACC_W + 1;
  localparam int unsigned RCP_SH = DVD_W + 3;
  localparam int unsigned RCP_W  = DVD_W + 1;
  localparam int unsigned PRD_W  = DVD_W + RCP_W;

  // ceil(2^RCP_SH / 7): exact floor(x/7) for every x below 2^DVD_W
  localparam logic [RCP_W-1:0] RECIP_DIV =
    RCP_W'(((64'd1 << RCP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  // Zero acts as one, above the ring length acts as the ring length
  function automatic logic [CNT_W-1:0] eff_period(input logic [REG_W-1:0] p);
    if (p == '0) begin
      return CNT_W'(1);
    end else if (32'(p) > 32'(MAX_PERIOD)) begin
      return CNT_W'(MAX_PERIOD);
    end else begin
      return CNT_W'(p);
    end
  endfunction

  back_state_e state_q, state_d;

  logic [1:0]              k_q;
  logic [PTR_W-1:0]        ptr_q;
  logic [CNT_W-1:0]        stored_q;
  logic signed [PS_W-1:0]  psum_q [3];
  logic [RS_W-1:0]         rsum_q [3];
  logic signed [BP_W-1:0]  bp_q;
  logic [PRICE_BITS-1:0]   tr_q;
  logic [MEM_W-1:0]        ring_mem [MAX_PERIOD];
  logic [MEM_W-1:0]        rdata_q;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [DVD_W-1:0]        dvd;
  logic [PRD_W-1:0]        rcp_prod;
  logic [DVD_W-3:0]        q7;
  logic [OSC_W-1:0]        res_osc_q, osc_fin;
  status_e                 res_status_q;
  logic                    out_valid_q;

  logic [CNT_W-1:0]        per_s, per_m, per_l, per_k;
  logic [IW-1:0]           idx_raw, idx_wrap;
  logic [PTR_W-1:0]        rd_idx;
  logic                    drop;
  logic signed [BP_W-1:0]  old_bp;
  logic [PRICE_BITS-1:0]   old_tr;
  logic signed [PS_W-1:0]  psum_upd;
  logic [RS_W-1:0]         rsum_upd;
  logic                    mem_we, div_start;
  logic [RAT_W-1:0]        ratio;
  div_sts_t                div_sts;
  logic                    out_load;

  assign per_s = eff_period(cfg_i.short_p);
  assign per_m = eff_period(cfg_i.mid_p);
  assign per_l = eff_period(cfg_i.long_p);

  // Window length of the sum under work
  always_comb begin
    unique case (k_q)
      WIN_SHORT: per_k = per_s;
      WIN_MID:   per_k = per_m;
      default:   per_k = per_l;
    endcase
  end

  // Ring slot that leaves the window
  always_comb begin
    idx_raw  = IW'(ptr_q) + IW'(MAX_PERIOD) - IW'(per_k);
    idx_wrap = (idx_raw >= IW'(MAX_PERIOD)) ? idx_raw - IW'(MAX_PERIOD) : idx_raw;
    rd_idx   = idx_wrap[PTR_W-1:0];
  end

  // Window sum update from the registered ring read
  always_comb begin
    old_bp   = signed'(rdata_q[MEM_W-1:PRICE_BITS]);
    old_tr   = rdata_q[PRICE_BITS-1:0];
    drop     = (stored_q >= per_k);
    psum_upd = psum_q[k_q] + PS_W'(bp_q);
    rsum_upd = rsum_q[k_q] + RS_W'(tr_q);
    if (drop) begin
      psum_upd = psum_upd - PS_W'(old_bp);
      rsum_upd = rsum_upd - RS_W'(old_tr);
    end
  end

  // Weighted ratio accumulation: 4, 2, 1
  assign acc_d = acc_q + (ACC_W'(ratio) << (2'd2 - k_q));

  // Divide 2*acc by seven with a reciprocal multiply
  always_comb begin
    dvd      = {acc_q, 1'b0};
    rcp_prod = PRD_W'(dvd) * PRD_W'(RECIP_DIV);
    q7       = rcp_prod[PRD_W-1:RCP_SH];
    osc_fin  = OSC_W'(acc_q) * OSC_W'(MUL_INT) + OSC_W'(q7);
  end

  assign out_load = (state_q == BK_FINISH) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          state_d = pop_first_i ? BK_FINISH : BK_READ;
        end
      end
      BK_READ: begin
        state_d = BK_ACC;
      end
      BK_ACC: begin
        state_d = (k_q == WIN_LONG) ? BK_WRITE : BK_READ;
      end
      BK_WRITE: begin
        mem_we  = 1'b1;
        state_d = BK_EVAL;
      end
      BK_EVAL: begin
        state_d = (cfg_i.bad || (stored_q < per_l)) ? BK_FINISH : BK_DIV_START;
      end
      BK_DIV_START: begin
        div_start = 1'b1;
        state_d   = BK_DIV_WAIT;
      end
      BK_DIV_WAIT: begin
        if (div_sts.done) begin
          state_d = (k_q == WIN_LONG) ? BK_SCALE : BK_DIV_START;
        end
      end
      BK_SCALE: begin
        state_d = BK_FINISH;
      end
      BK_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: pointers, counts, sums, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= WIN_SHORT;
      ptr_q       <= '0;
      stored_q    <= '0;
      psum_q      <= '{default: '0};
      rsum_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.clear) begin
        k_q      <= WIN_SHORT;
        ptr_q    <= '0;
        stored_q <= '0;
        psum_q   <= '{default: '0};
        rsum_q   <= '{default: '0};
      end else begin
        unique case (state_q)
          BK_IDLE: k_q <= WIN_SHORT;
          BK_ACC: begin
            psum_q[k_q] <= psum_upd;
            rsum_q[k_q] <= rsum_upd;
            k_q         <= (k_q == WIN_LONG) ? WIN_SHORT : k_q + 1'b1;
          end
          BK_WRITE: begin
            ptr_q <= (ptr_q == PTR_W'(MAX_PERIOD - 1)) ? '0 : ptr_q + 1'b1;
            if (stored_q < CNT_W'(MAX_PERIOD)) begin
              stored_q <= stored_q + 1'b1;
            end
          end
          BK_DIV_WAIT: begin
            if (div_sts.done) begin
              k_q <= (k_q == WIN_LONG) ? WIN_SHORT : k_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Bar payload, accumulation and scaling
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        bp_q         <= pop_bp_i;
        tr_q         <= pop_tr_i;
        acc_q        <= '0;
        res_osc_q    <= '0;
        res_status_q <= cfg_i.bad ? STATUS_BAD : STATUS_WARMUP;
      end
      BK_EVAL: begin
        res_osc_q <= '0;
        if (cfg_i.bad) begin
          res_status_q <= STATUS_BAD;
        end else if (stored_q < per_l) begin
          res_status_q <= STATUS_WARMUP;
        end else begin
          res_status_q <= STATUS_VALID;
        end
      end
      BK_DIV_WAIT: begin
        if (div_sts.done) begin
          acc_q <= acc_d;
        end
      end
      BK_SCALE: begin
        res_osc_q <= osc_fin;
      end
      default: ;
    endcase
  end

  // Ring memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[ptr_q] <= {bp_q, tr_q};
    end
    rdata_q <= ring_mem[rd_idx];
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_osc_o    <= res_osc_q;
      out_status_o <= res_status_q;
      out_bp_o     <= bp_q;
      out_tr_o     <= tr_q;
    end
  end

  assign out_valid_o = out_valid_q;

  uo_div #(
    .DEN_W     (RS_W),
    .NUM_W     (PS_W),
    .FRAC_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (psum_q[k_q]),
    .den_i   (rsum_q[k_q]),
    .quot_o  (ratio),
    .sts_o   (div_sts)
  );

endmodule

`default_nettype wire

// File: design/ultimate_oscillator_unit.sv
// Ultimate oscillator unit: APB registers, front end, bar queue and back end.
//
// Usage
//   Price bars enter on the s_axis stream (high, low, close in tdata), one
//   result per bar leaves on m_axis (oscillator, buying pressure and true range
//   in tdata, status in tuser). Periods are set over APB at byte addresses
//   0, 4 and 8; any write to one of them clears all bar state.
//   The time from input to output transaction is set by the three serial
//   window divisions in the back end; a window whose ratio is 0 or saturated
//   skips its bit-serial division. Warm-up and non-ascending bars skip the
//   divisions, and the first bar after clearing skips the window pass too.
//   Throughput is one bar per back-end pass; the two-entry queue and the
//   output register let the front end take bars while the back end works or
//   a result waits.
//   Reset clears the periods to 7, 14, 28 and empties all windows; the ring
//   memory needs no clearing pass because a slot is only read once written.
//   When the receiver stalls the result holds in the output register; the
//   back end then waits and the queue fills before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

`include "ultimate_oscillator_unit_assert.svh"

module ultimate_oscillator_unit import uo_pkg::*; #(
  parameter int unsigned MAX_PERIOD    = MAX_PERIOD_DEF,
  parameter int unsigned PRICE_BITS    = PRICE_BITS_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int unsigned IN_TD_W  = ((3 * PRICE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_TD_W = ((FRACTION_BITS + 2 * PRICE_BITS + 8 + 7) / 8) * 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // APB configuration port
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [ADDR_W-1:0]     paddr,
  input  wire  [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Bar input: high_price, low_price, close_price (from bit 0 up)
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire  [IN_TD_W-1:0]    s_axis_tdata,
  // Result: oscillator, buying_pressure, true_range (from bit 0 up)
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [OUT_TD_W-1:0]   m_axis_tdata,
  // Result kind: status
  output logic [1:0]            m_axis_tuser
);

  localparam int unsigned BP_W  = PRICE_BITS + 1;
  localparam int unsigned OSC_W = FRACTION_BITS + 7;
  localparam int unsigned Q_W   = 1 + BP_W + PRICE_BITS;
  localparam logic [OSC_W-1:0] OSC_MAX_V = OSC_W'(OSC_SCALE) << FRACTION_BITS;

  logic [REG_W-1:0]     short_q, mid_q, long_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en, reg_hit;
  cfg_t                 cfg;

  logic                 push_valid, push_ready, push_first;
  logic signed [PRICE_BITS:0] push_bp;
  logic [PRICE_BITS-1:0] push_tr;
  logic [Q_W-1:0]       q_pop_data;
  logic                 q_pop_valid, q_pop_ready;

  logic [OSC_W-1:0]     res_osc;
  logic [1:0]           res_status;
  logic signed [PRICE_BITS:0] res_bp;
  logic [PRICE_BITS-1:0] res_tr;

  // Register decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_hit = (32'(reg_idx) < 32'(REG_COUNT));
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= SHORT_RESET;
      mid_q   <= MID_RESET;
      long_q  <= LONG_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SHORT: short_q <= pwdata[REG_W-1:0];
        REG_MID:   mid_q   <= pwdata[REG_W-1:0];
        REG_LONG:  long_q  <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_SHORT: prdata = APB_DATA_W'(short_q);
      REG_MID:   prdata = APB_DATA_W'(mid_q);
      REG_LONG:  prdata = APB_DATA_W'(long_q);
      default:   prdata = '0;
    endcase
  end

  // Periods must satisfy 1 <= short < mid < long <= ring length
  always_comb begin
    cfg.short_p = short_q;
    cfg.mid_p   = mid_q;
    cfg.long_p  = long_q;
    cfg.bad     = (short_q == '0) || (32'(long_q) > 32'(MAX_PERIOD)) ||
                  !((short_q < mid_q) && (mid_q < long_q));
    cfg.clear   = wr_en && reg_hit;
  end

  uo_front #(
    .PRICE_BITS (PRICE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (cfg.clear),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .high_i       (s_axis_tdata[PRICE_BITS-1:0]),
    .low_i        (s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS]),
    .close_i      (s_axis_tdata[3*PRICE_BITS-1:2*PRICE_BITS]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_first_o (push_first),
    .push_bp_o    (push_bp),
    .push_tr_o    (push_tr)
  );

  uo_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_first, push_bp, push_tr}),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  uo_back #(
    .MAX_PERIOD    (MAX_PERIOD),
    .PRICE_BITS    (PRICE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .pop_valid_i  (q_pop_valid),
    .pop_ready_o  (q_pop_ready),
    .pop_first_i  (q_pop_data[Q_W-1]),
    .pop_bp_i     (signed'(q_pop_data[Q_W-2:PRICE_BITS])),
    .pop_tr_i     (q_pop_data[PRICE_BITS-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_osc_o    (res_osc),
    .out_status_o (res_status),
    .out_bp_o     (res_bp),
    .out_tr_o     (res_tr)
  );

  // Result packing
  assign m_axis_tdata = OUT_TD_W'({res_tr, res_bp, res_osc});
  assign m_axis_tuser = res_status;

  // Checks
  `UOU_ASSERT_IMP(a_osc_full_scale, m_axis_tvalid, res_osc <= OSC_MAX_V, "oscillator above full scale")
  `UOU_ASSERT_IMP(a_osc_zero, m_axis_tvalid && (res_status != STATUS_VALID), res_osc == '0, "osc set")
  `UOU_ASSERT_NXT(a_bar_reaches_queue, s_axis_tvalid && s_axis_tready, q_pop_valid, "bar lost")

endmodule

`default_nettype wire

// File: tb/uo_result_checker.sv
// Result checker for the ultimate oscillator unit: predicts each bar's result and compares.
`timescale 1ns / 1ps

module uo_result_checker import uo_pkg::*; #(
  parameter int unsigned PW    = PRICE_BITS_DEF,
  parameter int unsigned FW    = FRACTION_BITS_DEF,
  parameter int unsigned DEPTH = MAX_PERIOD_DEF,
  parameter int unsigned IN_W  = ((3 * PW + 7) / 8) * 8,
  parameter int unsigned OUT_W = ((FW + 2 * PW + 8 + 7) / 8) * 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // APB side, watched for register writes
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire                   pready,
  input  wire  [ADDR_W-1:0]     paddr,
  input  wire  [APB_DATA_W-1:0] pwdata,
  // Bar stream: high_price, low_price, close_price (from bit 0 up)
  input  wire                   s_axis_tvalid,
  input  wire                   s_axis_tready,
  input  wire  [IN_W-1:0]       s_axis_tdata,
  // Result stream: oscillator, buying_pressure, true_range (from bit 0 up)
  input  wire                   m_axis_tvalid,
  input  wire                   m_axis_tready,
  input  wire  [OUT_W-1:0]      m_axis_tdata,
  // Result kind: status
  input  wire  [1:0]            m_axis_tuser,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned OSC_W     = FW + 7;
  localparam int unsigned TR_LO     = OSC_W + PW + 1;
  localparam int unsigned DUE_DEPTH = 16;

  typedef struct packed {
    logic [OSC_W-1:0] osc;
    status_e          status;
    logic [PW:0]      pressure;
    logic [PW-1:0]    span;
  } bar_result_t;

  // Periods as last written
  logic [REG_W-1:0] short_len, mid_len, long_len;

  // Bar history and window sums
  logic [PW-1:0]        last_cl;
  logic                 last_cl_ok;
  logic signed [PW:0]   push_ring [DEPTH];
  logic [PW-1:0]        span_ring [DEPTH];
  int unsigned          wr_ptr;
  int unsigned          filled;
  longint               push_sum [3];
  longint               span_sum [3];

  // Predicted results waiting for the block, in order
  bar_result_t          due_ring [DUE_DEPTH];
  int unsigned          due_wr;
  int unsigned          due_rd;
  int unsigned          miss_total;

  function automatic void forget_bars();
    last_cl    = '0;
    last_cl_ok = 1'b0;
    wr_ptr     = 0;
    filled     = 0;
    for (int k = 0; k < 3; k++) begin
      push_sum[k] = 0;
      span_sum[k] = 0;
    end
  endfunction

  function automatic int unsigned window_len(logic [REG_W-1:0] p);
    if (p == 0) return 1;
    if (p > DEPTH) return DEPTH;
    return p;
  endfunction

  function automatic logic order_broken();
    if (short_len == 0 || long_len > DEPTH) return 1'b1;
    return !(short_len < mid_len && mid_len < long_len);
  endfunction

  // Truncated num/den in [0,1] with FW fraction bits; negative or empty gives 0
  function automatic logic [FW:0] window_frac(longint num, longint den);
    longint      rem;
    logic [FW:0] q;
    if (den <= 0 || num <= 0) return '0;
    if (num >= den) return (FW + 1)'(1) << FW;
    rem = num;
    q   = '0;
    for (int i = 0; i < FW; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Advance the bar history by one bar and work out its result
  function automatic bar_result_t score_bar(logic [PW-1:0] hi, logic [PW-1:0] lo,
                                            logic [PW-1:0] cl);
    bar_result_t        res;
    logic [PW-1:0]      lo_floor, hi_ceil, span;
    logic signed [PW:0] push;
    int unsigned        win [3];
    int unsigned        slot;
    int unsigned        acc;
    logic               broken;
    broken       = order_broken();
    res.osc      = '0;
    res.pressure = '0;
    res.span     = '0;
    res.status   = broken ? STATUS_BAD : STATUS_WARMUP;
    // no previous close yet: only remember this one
    if (!last_cl_ok) begin
      last_cl    = cl;
      last_cl_ok = 1'b1;
      return res;
    end
    lo_floor = (lo < last_cl) ? lo : last_cl;
    hi_ceil  = (hi > last_cl) ? hi : last_cl;
    push     = $signed({1'b0, cl}) - $signed({1'b0, lo_floor});
    span     = hi_ceil - lo_floor;
    win[0]   = window_len(short_len);
    win[1]   = window_len(mid_len);
    win[2]   = window_len(long_len);
    for (int k = 0; k < 3; k++) begin
      push_sum[k] = push_sum[k] + longint'(push);
      span_sum[k] = span_sum[k] + longint'(span);
      if (filled >= win[k]) begin
        slot        = (wr_ptr + DEPTH - win[k]) % DEPTH;
        push_sum[k] = push_sum[k] - longint'(push_ring[slot]);
        span_sum[k] = span_sum[k] - longint'(span_ring[slot]);
      end
    end
    push_ring[wr_ptr] = push;
    span_ring[wr_ptr] = span;
    wr_ptr            = (wr_ptr + 1) % DEPTH;
    if (filled < DEPTH) filled++;
    last_cl = cl;

    if (!broken && filled >= win[2]) begin
      acc        = 4 * window_frac(push_sum[0], span_sum[0])
                 + 2 * window_frac(push_sum[1], span_sum[1])
                 + window_frac(push_sum[2], span_sum[2]);
      res.osc    = OSC_W'((acc * 100) / 7);
      res.status = STATUS_VALID;
    end
    res.pressure = push;
    res.span     = span;
    return res;
  endfunction

  function automatic void flag_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
      miss_total++;
    end
  endfunction

  // Watch all three ports at each clock edge
  always @(posedge clk_i or negedge rst_ni) begin : watch_ports
    bar_result_t got, want;
    if (!rst_ni) begin
      short_len  = SHORT_RESET;
      mid_len    = MID_RESET;
      long_len   = LONG_RESET;
      forget_bars();
      due_wr     = 0;
      due_rd     = 0;
      miss_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register write: any known register clears the history
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SHORT: begin
            short_len = pwdata[REG_W-1:0];
            forget_bars();
          end
          REG_MID: begin
            mid_len = pwdata[REG_W-1:0];
            forget_bars();
          end
          REG_LONG: begin
            long_len = pwdata[REG_W-1:0];
            forget_bars();
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due_ring[due_wr % DUE_DEPTH] = score_bar(s_axis_tdata[0 +: PW], s_axis_tdata[PW +: PW],
                                                 s_axis_tdata[2 * PW +: PW]);
        due_wr++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.osc      = m_axis_tdata[OSC_W-1:0];
        got.pressure = m_axis_tdata[TR_LO-1 -: PW + 1];
        got.span     = m_axis_tdata[TR_LO +: PW];
        got.status   = status_e'(m_axis_tuser);
        if (due_wr == due_rd) begin
          $display("%0t ns: result with none due, expected none actual %h/%0d",
                   $time, m_axis_tdata, m_axis_tuser);
          miss_total++;
        end else begin
          want = due_ring[due_rd % DUE_DEPTH];
          due_rd++;
          flag_field("oscillator", 64'(want.osc), 64'(got.osc));
          flag_field("status", 64'(want.status), 64'(got.status));
          flag_field("buying_pressure", 64'(want.pressure), 64'(got.pressure));
          flag_field("true_range", 64'(want.span), 64'(got.span));
        end
      end
      fail_count_o <= miss_total;
      pending_o    <= due_wr - due_rd;
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the ultimate oscillator unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import uo_pkg::*;

  localparam int unsigned PW               = PRICE_BITS_DEF;
  localparam int unsigned IN_W             = ((3 * PW + 7) / 8) * 8;
  localparam int unsigned OUT_W            = ((FRACTION_BITS_DEF + 2 * PW + 8 + 7) / 8) * 8;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [PW-1:0] P_MAX          = '1;
  localparam int unsigned LONG_HOLD_AT     = 150;
  localparam int unsigned LONG_HOLD_LEN    = 600;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel, penable, pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0] pwdata;
  wire  [APB_DATA_W-1:0] prdata;
  wire                   pready;
  logic                  s_axis_tvalid;
  wire                   s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready;
  wire  [OUT_W-1:0]      m_axis_tdata;
  wire  [1:0]            m_axis_tuser;
  int unsigned           fail_count;
  int unsigned           pending;

  // Idle shaping of both stream sides
  int unsigned           gap_pct;
  int unsigned           stall_pct;
  bit                    calm;

  // Price walk for well-formed bars
  logic [PW-1:0]         walk_level;
  logic [PW-1:0]         bar_close;

  ultimate_oscillator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  uo_result_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Result side: random stall bursts plus one long hold-off to back up the queue
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned taken;
    bit          held;
    stall_left = 0;
    hold_left  = 0;
    taken      = 0;
    held       = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
      if (!held && taken == LONG_HOLD_AT) begin
        held      = 1'b1;
        hold_left = LONG_HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int unsigned idle_share();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  function automatic logic [PW-1:0] extreme_price();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return P_MAX;
      default: return PW'($urandom);
    endcase
  endfunction

  // Mostly bars around a drifting price, with flat bars and noise mixed in
  task automatic make_bar(output logic [PW-1:0] h, output logic [PW-1:0] l,
                          output logic [PW-1:0] c);
    int unsigned   pick;
    logic [PW-1:0] spread;
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      spread     = PW'($urandom) >> $urandom_range(8, 31);
      walk_level = walk_level + (PW'($urandom) >> $urandom_range(10, 31))
                              - (PW'($urandom) >> $urandom_range(10, 31));
      c = walk_level;
      h = c + ($urandom % (spread + 1));
      l = c - ($urandom % (spread + 1));
    end else if (pick < 86) begin
      h = bar_close;
      l = bar_close;
      c = bar_close;
    end else if (pick < 95) begin
      h = PW'($urandom);
      l = PW'($urandom);
      c = PW'($urandom);
    end else begin
      h = extreme_price();
      l = extreme_price();
      c = extreme_price();
    end
    bar_close = c;
  endtask

  task automatic send_bar(input logic [PW-1:0] h, input logic [PW-1:0] l,
                          input logic [PW-1:0] c);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tdata  <= IN_W'({c, l, h});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // psel stays high across back-to-back writes; the caller drops it
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    logic [APB_DATA_W-1:0] word;
    word          = $urandom;
    word[REG_W-1:0] = val;
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic run_phase(input logic [REG_W-1:0] s, input logic [REG_W-1:0] m,
                           input logic [REG_W-1:0] lg, input int unsigned n);
    logic [PW-1:0] h, l, c;
    drain();
    write_reg(REG_SHORT, s);
    write_reg(REG_MID, m);
    write_reg(REG_LONG, lg);
    psel   <= 1'b0;
    pwrite <= 1'b0;
    gap_pct   = idle_share();
    stall_pct = idle_share();
    repeat (n) begin
      make_bar(h, l, c);
      send_bar(h, l, c);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Stimulus
  initial begin : stimulus
    logic [PW-1:0]    h, l, c;
    logic [REG_W-1:0] s, m, lg;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    gap_pct    = 15;
    stall_pct  = 15;
    calm       = 1'b0;
    walk_level = PW'(32'h4000_0000 + $urandom_range(0, 32'h3FFF_FFFF));
    bar_close  = walk_level;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bars at the reset periods: first bar, price extremes
    send_bar(P_MAX, '0, P_MAX);
    send_bar(P_MAX, '0, '0);
    send_bar('0, P_MAX, P_MAX);
    send_bar('0, '0, '0);
    send_bar('0, '0, P_MAX);
    send_bar(P_MAX, P_MAX, '0);
    s_axis_tvalid <= 1'b0;

    // unmapped register: write is dropped and the history survives
    drain();
    write_reg(REG_SPARE, REG_W'($urandom));
    psel   <= 1'b0;
    pwrite <= 1'b0;

    // flat bars (zero range), close above high, close at high, close below low
    repeat (4) send_bar(32'd5000, 32'd5000, 32'd5000);
    send_bar(32'd5200, 32'd4900, 32'd5600);
    send_bar(32'd5600, 32'd5100, 32'd5600);
    send_bar(32'd5700, 32'd5300, 32'd5000);
    send_bar(32'd5100, 32'd4700, 32'd4700);
    bar_close = 32'd4700;
    walk_level = 32'd4700;
    repeat (280) begin
      make_bar(h, l, c);
      send_bar(h, l, c);
    end
    s_axis_tvalid <= 1'b0;
    walk_level = PW'(32'h4000_0000 + $urandom_range(0, 32'h3FFF_FFFF));

    // Period extremes, then bad settings: zero, equal, descending, beyond the ring
    run_phase(7'd1, 7'd2, 7'd3, 150);
    run_phase(7'd62, 7'd63, 7'd64, 200);
    run_phase(7'd1, 7'd2, 7'd64, 150);
    run_phase(7'd1, 7'd63, 7'd64, 120);
    run_phase(7'd0, 7'd3, 7'd5, 60);
    run_phase(7'd5, 7'd5, 7'd10, 60);
    run_phase(7'd10, 7'd5, 7'd3, 60);
    run_phase(7'd3, 7'd10, 7'd100, 60);
    run_phase(7'd127, 7'd127, 7'd127, 40);
    run_phase(7'd0, 7'd0, 7'd0, 40);

    // Random periods, mostly ascending
    repeat (6) begin
      if ($urandom_range(0, 3) != 0) begin
        s  = REG_W'($urandom_range(1, 62));
        m  = REG_W'($urandom_range(s + 1, 63));
        lg = REG_W'($urandom_range(m + 1, 64));
      end else begin
        s  = REG_W'($urandom_range(0, 127));
        m  = REG_W'($urandom_range(0, 127));
        lg = REG_W'($urandom_range(0, 127));
      end
      run_phase(s, m, lg, 80);
    end

    // Closing stretch at full rate
    calm = 1'b1;
    run_phase(7'd2, 7'd5, 7'd9, 100);

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
